// ===== hw/rtl/vlts_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vlts_pkg
// Shared types and constants of the vision link task-switch handler.
// ---------------------------------------------------------------------------
package vlts_pkg;

    // Event kinds carried on s_tuser
    localparam logic [2:0] MODE_RX_BYTE = 3'd0;
    localparam logic [2:0] MODE_TICK    = 3'd1;
    localparam logic [2:0] MODE_SELECT  = 3'd2;
    localparam logic [2:0] MODE_TX_DONE = 3'd3;
    localparam logic [2:0] MODE_LINK_ERR = 3'd4;

    // Link characters
    localparam logic [7:0] CMD_NUMBER = 8'h4E;  // 'N'
    localparam logic [7:0] CMD_BEAN   = 8'h42;  // 'B'
    localparam logic [7:0] ACK_NUMBER = 8'h6E;  // 'n'
    localparam logic [7:0] ACK_BEAN   = 8'h62;  // 'b'
    localparam logic [7:0] CHR_ONE    = 8'h31;  // '1'
    localparam logic [7:0] CHR_FIVE   = 8'h35;  // '5'
    localparam logic [7:0] CHR_L      = 8'h4C;  // 'L'
    localparam logic [7:0] CHR_H      = 8'h48;  // 'H'

    // Semantic codes of the bean task
    localparam logic [3:0] SEM_NONE   = 4'd0;
    localparam logic [3:0] SEM_BEAN_L = 4'd6;
    localparam logic [3:0] SEM_BEAN_H = 4'd7;
    localparam logic [3:0] SEM_BEAN_B = 4'd8;

    localparam logic [15:0] DEFAULT_TIMEOUT = 16'd10000;

    // Register map (byte addresses)
    localparam int          PADDR_W         = 3;
    localparam logic [2:0]  ADDR_TIMEOUT    = 3'd0;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    typedef enum logic [1:0] {
        SW_IDLE    = 2'd0,
        SW_PENDING = 2'd1,
        SW_FAILED  = 2'd2
    } sw_status_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] rx_byte;
        logic       task_choice;
    } event_t;

    typedef struct packed {
        logic        result_valid;
        logic [3:0]  semantic;
        logic        result_task;
        logic [15:0] sequence_res;
        logic        result_cleared;
        logic        format_error;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [1:0]  switch_state;
        logic        timed_out;
        logic        online;
        logic        selected_task;
    } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/vision_link_task_switch_handler.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vision_link_task_switch_handler
// Host-side task-switch handler of a one-character vision coprocessor link.
// ---------------------------------------------------------------------------
// Every input beat is one event (received byte, tick, task select, tx done,
// link error) and yields exactly one result beat with the link status after
// that event. The block takes one event per clock while the master
// side keeps taking results: the event sits in an input register, the
// event logic works on it in one pass and the result lands in an output
// register, which drives m_tvalid. Back-pressure on the master side
// stalls the pipeline only once both registers are full. The acknowledge
// timeout register (switch_timeout_ticks, byte address 0, reset 10000,
// zero acts as one) is counted in tick events, not clock cycles, and must
// be written while the block is idle.
// ---------------------------------------------------------------------------
module vision_link_task_switch_handler (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // event stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [vlts_pkg::S_TDATA_W-1:0]   s_tdata,  // rx_byte[7:0], task_choice[8], 0
    input  wire logic [2:0]                       s_tuser,  // mode[2:0]
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // result_valid[0], semantic[4:1], result_task[5], sequence_res[21:6],
    // result_cleared[22], format_error[23], tx_valid[24], tx_byte[32:25],
    // switch_state[34:33], timed_out[35], online[36], selected_task[37], 0
    output logic [vlts_pkg::M_TDATA_W-1:0]        m_tdata,
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [vlts_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import vlts_pkg::*;

    logic        item_valid;
    event_t      item;
    result_t     result;
    logic        out_free;
    logic        advance;
    logic [15:0] timeout_reg;

    // an event moves on when the result register can take its result
    assign advance = item_valid && out_free;

    // APB: zero wait states, single register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TIMEOUT) ? {16'd0, timeout_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= DEFAULT_TIMEOUT;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_TIMEOUT)
        begin
            timeout_reg <= pwdata[15:0];
        end
    end

    vlts_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    vlts_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .item          (item),
        .timeout_ticks (timeout_reg),
        .result        (result)
    );

    vlts_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef NO_ASSERTIONS
    // input side stalls only when both pipeline registers are full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (item_valid && m_tvalid && !m_tready))
        else $error("input stalled with a free pipeline slot");

    // a sent command is always one of the two task commands
    a_tx_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[24]) |->
            (m_tdata[32:25] == CMD_NUMBER || m_tdata[32:25] == CMD_BEAN))
        else $error("bad command byte");

    // a published result has a semantic code and no format error
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[4:1] != SEM_NONE && !m_tdata[23]))
        else $error("malformed published result");

    // timeout leaves the switch failed and the link offline
    a_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[35]) |-> (m_tdata[34:33] == SW_FAILED || m_tdata[24])
            && !m_tdata[36])
        else $error("timeout without failure");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/vlts_in_stage.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vlts_in_stage
// Input register: captures one event beat and holds it until the core
// hands its result to the output register.
// ---------------------------------------------------------------------------
module vlts_in_stage (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [vlts_pkg::S_TDATA_W-1:0]   s_tdata,  // rx_byte[7:0], task_choice[8]
    input  wire logic [2:0]                       s_tuser,  // mode[2:0]
    input  wire logic                             advance,
    output logic                                  item_valid,
    output vlts_pkg::event_t                      item
);
    import vlts_pkg::*;

    logic   valid_reg;
    event_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.mode        <= s_tuser;
            item_reg.rx_byte     <= s_tdata[7:0];
            item_reg.task_choice <= s_tdata[8];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/vlts_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vlts_core
// Link state and the single-pass event logic; state commits on advance.
// ---------------------------------------------------------------------------
module vlts_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire vlts_pkg::event_t  item,
    input  wire logic [15:0]       timeout_ticks,
    output vlts_pkg::result_t      result
);
    import vlts_pkg::*;

    logic        cur_task_reg,  cur_task_next;
    logic        want_task_reg, want_task_next;
    logic        queued_reg,    queued_next;
    logic        awaiting_reg,  awaiting_next;
    sw_status_t  status_reg,    status_next;
    logic [15:0] countdown_reg, countdown_next;
    logic        tx_busy_reg,   tx_busy_next;
    logic [15:0] seq_reg,       seq_next;
    logic        alive_reg,     alive_next;

    logic        acked;
    logic [3:0]  sem;
    logic [15:0] cd_dec;

    always_comb
    begin
        cur_task_next  = cur_task_reg;
        want_task_next = want_task_reg;
        queued_next    = queued_reg;
        awaiting_next  = awaiting_reg;
        status_next    = status_reg;
        countdown_next = countdown_reg;
        tx_busy_next   = tx_busy_reg;
        seq_next       = seq_reg;
        alive_next     = alive_reg;
        result         = '0;
        acked          = (item.rx_byte == ACK_BEAN);
        cd_dec         = (countdown_reg != 16'd0) ? countdown_reg - 16'd1 : 16'd0;

        // classify under the committed task
        sem = SEM_NONE;
        if (!cur_task_reg)
        begin
            if (item.rx_byte >= CHR_ONE && item.rx_byte <= CHR_FIVE)
            begin
                sem = item.rx_byte[3:0];
            end
        end
        else if (item.rx_byte == CHR_L)
        begin
            sem = SEM_BEAN_L;
        end
        else if (item.rx_byte == CHR_H)
        begin
            sem = SEM_BEAN_H;
        end
        else if (item.rx_byte == CMD_BEAN)
        begin
            sem = SEM_BEAN_B;
        end

        case (item.mode)
            MODE_RX_BYTE:
            begin
                if (item.rx_byte == ACK_NUMBER || item.rx_byte == ACK_BEAN)
                begin
                    if (awaiting_reg && acked == want_task_reg)
                    begin
                        awaiting_next         = 1'b0;
                        cur_task_next         = acked;
                        status_next           = SW_IDLE;
                        result.result_cleared = 1'b1;
                        alive_next            = 1'b1;
                    end
                end
                else if (!queued_reg && !awaiting_reg)
                begin
                    if (sem != SEM_NONE)
                    begin
                        result.result_valid = 1'b1;
                        result.semantic     = sem;
                        result.result_task  = cur_task_reg;
                        result.sequence_res = seq_reg;
                        seq_next            = seq_reg + 16'd1;
                        alive_next          = 1'b1;
                    end
                    else
                    begin
                        result.format_error = 1'b1;
                    end
                end
            end
            MODE_TICK:
            begin
                // running wait counts down before a queued command goes out
                if (awaiting_reg)
                begin
                    countdown_next = cd_dec;
                    if (cd_dec == 16'd0)
                    begin
                        awaiting_next    = 1'b0;
                        status_next      = SW_FAILED;
                        alive_next       = 1'b0;
                        result.timed_out = 1'b1;
                    end
                end
                if (queued_reg && !tx_busy_reg)
                begin
                    result.tx_valid = 1'b1;
                    result.tx_byte  = want_task_reg ? CMD_BEAN : CMD_NUMBER;
                    tx_busy_next    = 1'b1;
                    queued_next     = 1'b0;
                    awaiting_next   = 1'b1;
                    countdown_next  = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
                end
            end
            MODE_SELECT:
            begin
                want_task_next        = item.task_choice;
                queued_next           = 1'b1;
                awaiting_next         = 1'b0;
                status_next           = SW_PENDING;
                result.result_cleared = 1'b1;
            end
            MODE_TX_DONE:
            begin
                tx_busy_next = 1'b0;
            end
            MODE_LINK_ERR:
            begin
                alive_next = 1'b0;
            end
            default:
            begin
                // unused kinds only report state
            end
        endcase

        result.switch_state  = status_next;
        result.online        = alive_next;
        result.selected_task = cur_task_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_task_reg  <= 1'b0;
            want_task_reg <= 1'b0;
            queued_reg    <= 1'b0;
            awaiting_reg  <= 1'b0;
            status_reg    <= SW_IDLE;
            countdown_reg <= 16'd0;
            tx_busy_reg   <= 1'b0;
            seq_reg       <= 16'd1;
            alive_reg     <= 1'b0;
        end
        else if (advance)
        begin
            cur_task_reg  <= cur_task_next;
            want_task_reg <= want_task_next;
            queued_reg    <= queued_next;
            awaiting_reg  <= awaiting_next;
            status_reg    <= status_next;
            countdown_reg <= countdown_next;
            tx_busy_reg   <= tx_busy_next;
            seq_reg       <= seq_next;
            alive_reg     <= alive_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/vlts_out_stage.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vlts_out_stage
// Result register: holds one result beat until the sink takes it.
// ---------------------------------------------------------------------------
module vlts_out_stage (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             load,
    input  wire vlts_pkg::result_t                result,
    output logic                                  free,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [vlts_pkg::M_TDATA_W-1:0]        m_tdata
);
    import vlts_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00,
                       res_reg.selected_task,
                       res_reg.online,
                       res_reg.timed_out,
                       res_reg.switch_state,
                       res_reg.tx_byte,
                       res_reg.tx_valid,
                       res_reg.format_error,
                       res_reg.result_cleared,
                       res_reg.sequence_res,
                       res_reg.result_task,
                       res_reg.semantic,
                       res_reg.result_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the vision link task-switch handler.
// ---------------------------------------------------------------------------
// Events go in on the slave stream and results come back on the master
// stream, one result beat per event. The bench keeps its own model of the
// link state, predicts every result beat from each accepted event beat,
// and compares it field by field with the oldest prediction in line.
// Stimulus runs in three parts:
//   - a short directed table
//   - random phases, each under a different ack timeout setting
//   - a last phase with no idling on either side
// The random phases are mostly complete task switches: select, tx done,
// tick, ack, then valid bytes for that task. Single noise events fill the
// rest. The timeout register is only written while no results are
// outstanding.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vlts_pkg::*;

    // One row of the directed table. When has_result is set, the result is
    // written out by hand and checked as is. Otherwise the row is checked
    // against the prediction.
    typedef struct {
        logic [2:0] kind;
        logic [7:0] ch;
        logic       choice;
        bit         has_result;
        result_t    res;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;    // rx_byte[7:0], task_choice[8], 0
    logic [2:0]             s_tuser;    // mode[2:0]
    logic                   m_tvalid;
    logic                   m_tready;
    // result_valid[0], semantic[4:1], result_task[5], sequence_res[21:6],
    // result_cleared[22], format_error[23], tx_valid[24], tx_byte[32:25],
    // switch_state[34:33], timed_out[35], online[36], selected_task[37], 0
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    // Model of the link, updated once per accepted event beat
    logic        cur_task;
    logic        want_task;
    logic        queued;
    logic        waiting;
    sw_status_t  status;
    logic [15:0] countdown;
    logic        tx_busy;
    logic [15:0] seq_next;
    logic        alive;
    logic [15:0] ack_limit;     // mirror of switch_timeout_ticks

    result_t     link_reports_due[$];   // predicted result beats, oldest first
    dir_row_t    dir_rows[$];
    int          mismatches;
    int          events_sent;   // beats with a meaningful mode
    bit          calm;          // no idling on either side
    bit          stall_request; // ask the receiver for one long hold-off
    bit          row_typed;     // the beat on the bus carries a written-out result
    result_t     row_result;

    vision_link_task_switch_handler uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog. The run is about 650 event beats with random idling on each
    // side, the long hold-off and the settle waits; the watchdog fails the run
    // after five milliseconds.
    initial
    begin
        #(5_000_000);
        $display("** vision_link_task_switch_handler: FAILED **");
        $finish;
    end

    // Next link report: applies one event to the model and returns the
    // result beat it must produce. Event order follows the block.
    function automatic result_t next_link_report(input logic [2:0] kind, input logic [7:0] ch,
                                                 input logic choice);
        result_t r;
        logic [3:0] sem;
        logic acked;
        r = '0;
        sem = SEM_NONE;
        acked = (ch == ACK_BEAN);
        case (kind)
            MODE_RX_BYTE:
            begin
                if (ch == ACK_NUMBER || ch == ACK_BEAN)
                begin
                    // Stray or wrong-task ack: no effect and no error
                    if (waiting && acked == want_task)
                    begin
                        waiting = 1'b0;
                        cur_task = acked;
                        status = SW_IDLE;
                        r.result_cleared = 1'b1;
                        alive = 1'b1;
                    end
                end
                else if (!queued && !waiting)
                begin
                    if (!cur_task)
                    begin
                        // '1'..'5' carry their digit in the low nibble
                        if (ch >= CHR_ONE && ch <= CHR_FIVE)
                            sem = ch[3:0];
                    end
                    else if (ch == CHR_L)
                        sem = SEM_BEAN_L;
                    else if (ch == CHR_H)
                        sem = SEM_BEAN_H;
                    else if (ch == CMD_BEAN)    // 'B'
                        sem = SEM_BEAN_B;
                    if (sem != SEM_NONE)
                    begin
                        r.result_valid = 1'b1;
                        r.semantic = sem;
                        r.result_task = cur_task;
                        r.sequence_res = seq_next;
                        seq_next = seq_next + 16'd1;
                        alive = 1'b1;
                    end
                    else
                        r.format_error = 1'b1;
                end
                // otherwise a switch is in flight and the byte is dropped
            end
            MODE_TICK:
            begin
                // running wait counts down before a queued command goes out
                if (waiting)
                begin
                    if (countdown != 16'd0)
                        countdown = countdown - 16'd1;
                    if (countdown == 16'd0)
                    begin
                        waiting = 1'b0;
                        status = SW_FAILED;
                        alive = 1'b0;
                        r.timed_out = 1'b1;
                    end
                end
                if (queued && !tx_busy)
                begin
                    r.tx_valid = 1'b1;
                    r.tx_byte = want_task ? CMD_BEAN : CMD_NUMBER;
                    tx_busy = 1'b1;
                    queued = 1'b0;
                    waiting = 1'b1;
                    countdown = (ack_limit == 16'd0) ? 16'd1 : ack_limit;
                end
            end
            MODE_SELECT:
            begin
                want_task = choice;
                queued = 1'b1;
                waiting = 1'b0;
                status = SW_PENDING;
                r.result_cleared = 1'b1;
            end
            MODE_TX_DONE:
                tx_busy = 1'b0;
            MODE_LINK_ERR:
                alive = 1'b0;
            default:
                ;
        endcase
        r.switch_state = status;
        r.online = alive;
        r.selected_task = cur_task;
        return r;
    endfunction

    // Written-out result for the directed rows. Those rows all sit in the
    // number task with the transmitter quiet, so the other fields stay zero.
    function automatic result_t plain_result(input logic valid, input logic [3:0] sem,
                                             input logic [15:0] seq, input logic cleared,
                                             input logic fmt_err, input sw_status_t st,
                                             input logic up);
        result_t r;
        r = '0;
        r.result_valid = valid;
        r.semantic = sem;
        r.sequence_res = seq;
        r.result_cleared = cleared;
        r.format_error = fmt_err;
        r.switch_state = st;
        r.online = up;
        return r;
    endfunction

    function automatic dir_row_t row(input logic [2:0] kind, input logic [7:0] ch,
                                     input logic choice);
        dir_row_t d;
        d.kind = kind;
        d.ch = ch;
        d.choice = choice;
        d.has_result = 1'b0;
        d.res = '0;
        return d;
    endfunction

    function automatic dir_row_t checked_row(input logic [2:0] kind, input logic [7:0] ch,
                                             input result_t res);
        dir_row_t d;
        d = row(kind, ch, 1'b0);
        d.has_result = 1'b1;
        d.res = res;
        return d;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            if (mismatches < 50)
                $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Result side: predictions are made at the accept edge of each event
    // beat, and every result beat is checked against the oldest one.
    always @(posedge clk)
    begin : result_monitor
        result_t predicted;
        result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predicted = next_link_report(s_tuser, s_tdata[7:0], s_tdata[8]);
                link_reports_due.push_back(row_typed ? row_result : predicted);
            end
            if (m_tvalid && m_tready)
            begin
                if (link_reports_due.size() == 0)
                begin
                    $error("result beat with no event waiting for it");
                    mismatches++;
                end
                else
                begin
                    want = link_reports_due.pop_front();
                    check_field("result_valid", 16'(want.result_valid), 16'(m_tdata[0]));
                    check_field("semantic", 16'(want.semantic), 16'(m_tdata[4:1]));
                    check_field("result_task", 16'(want.result_task), 16'(m_tdata[5]));
                    check_field("sequence_res", want.sequence_res, m_tdata[21:6]);
                    check_field("result_cleared", 16'(want.result_cleared),
                                16'(m_tdata[22]));
                    check_field("format_error", 16'(want.format_error), 16'(m_tdata[23]));
                    check_field("tx_valid", 16'(want.tx_valid), 16'(m_tdata[24]));
                    check_field("tx_byte", 16'(want.tx_byte), 16'(m_tdata[32:25]));
                    check_field("switch_state", 16'(want.switch_state),
                                16'(m_tdata[34:33]));
                    check_field("timed_out", 16'(want.timed_out), 16'(m_tdata[35]));
                    check_field("online", 16'(want.online), 16'(m_tdata[36]));
                    check_field("selected_task", 16'(want.selected_task),
                                16'(m_tdata[37]));
                end
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off when asked, none
    // while calm is set.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                m_tready <= 1'b0;
                repeat (40) @(negedge clk);
                stall_request = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Offer one event beat and wait for it to be taken. s_tvalid stays high
    // after the accept edge. The next call or settle() changes it at the
    // following falling edge.
    task automatic send_event(input logic [2:0] kind, input logic [7:0] ch, input logic choice,
                              input bit typed, input result_t typed_res);
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {7'd0, choice, ch};
        row_typed = typed;
        row_result = typed_res;
        do @(posedge clk); while (!s_tready);
        if (kind <= MODE_LINK_ERR)
            events_sent++;
    endtask

    task automatic post(input logic [2:0] kind, input logic [7:0] ch, input logic choice);
        send_event(kind, ch, choice, 1'b0, '0);
    endtask

    // Wait for every predicted result to come back, with a bound, then let the
    // two-stage pipeline go quiet.
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (link_reports_due.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        if (link_reports_due.size() != 0)
        begin
            $error("%0d expected result beats never arrived", link_reports_due.size());
            mismatches++;
            link_reports_due.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [15:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_TIMEOUT;
        pwdata <= {16'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        ack_limit = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_check_timeout();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_TIMEOUT;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {16'd0, ack_limit})
        begin
            $error("switch_timeout_ticks: expected %0h, got %0h", ack_limit, prdata);
            mismatches++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Select, maybe free the transmitter, tick the command out, maybe let a
    // few ticks pass (which times out short waits), ack, then a few bytes
    // for the chosen task.
    task automatic switch_sequence();
        logic pick;
        logic [7:0] ch;
        pick = 1'($urandom_range(0, 1));
        post(MODE_SELECT, 8'($urandom_range(0, 255)), pick);
        if ($urandom_range(0, 2) != 0)
            post(MODE_TX_DONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        post(MODE_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 2))
            post(MODE_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 5) != 0)
            post(MODE_RX_BYTE, pick ? ACK_BEAN : ACK_NUMBER, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 5))
        begin
            case ($urandom_range(0, 5))
                0:       ch = 8'($urandom_range(0, 255));
                1:       ch = CHR_L;
                2:       ch = CHR_H;
                3:       ch = CMD_BEAN;
                default: ch = 8'($urandom_range(CHR_ONE, CHR_FIVE));
            endcase
            post(MODE_RX_BYTE, ch, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic noise_event();
        logic [2:0] kind;
        if ($urandom_range(0, 9) == 0)
            kind = 3'($urandom_range(5, 7));
        else
            kind = 3'($urandom_range(0, 4));
        post(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin : stimulus
        logic [15:0] limits [5];
        int target;
        // quiet bus from time zero
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = MODE_RX_BYTE;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_TIMEOUT;
        pwdata = '0;
        mismatches = 0;
        events_sent = 0;
        calm = 1'b0;
        stall_request = 1'b0;
        row_typed = 1'b0;
        row_result = '0;

        // model reset state
        cur_task = 1'b0;
        want_task = 1'b0;
        queued = 1'b0;
        waiting = 1'b0;
        status = SW_IDLE;
        countdown = '0;
        tx_busy = 1'b0;
        seq_next = 16'd1;
        alive = 1'b0;
        ack_limit = DEFAULT_TIMEOUT;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        apb_check_timeout();        // reset value
        apb_write(16'd2);           // short wait so the table reaches a timeout
        apb_check_timeout();

        // Directed table
        // number task after reset, both digit extremes, then bytes that fail
        dir_rows.push_back(checked_row(MODE_RX_BYTE, CHR_ONE,
            plain_result(1'b1, 4'd1, 16'd1, 1'b0, 1'b0, SW_IDLE, 1'b1)));
        dir_rows.push_back(checked_row(MODE_RX_BYTE, CHR_FIVE,
            plain_result(1'b1, 4'd5, 16'd2, 1'b0, 1'b0, SW_IDLE, 1'b1)));
        dir_rows.push_back(checked_row(MODE_RX_BYTE, 8'h00,
            plain_result(1'b0, SEM_NONE, 16'd0, 1'b0, 1'b1, SW_IDLE, 1'b1)));
        dir_rows.push_back(checked_row(MODE_RX_BYTE, 8'hFF,
            plain_result(1'b0, SEM_NONE, 16'd0, 1'b0, 1'b1, SW_IDLE, 1'b1)));
        // ack with no wait running: ignored, no error
        dir_rows.push_back(checked_row(MODE_RX_BYTE, ACK_NUMBER,
            plain_result(1'b0, SEM_NONE, 16'd0, 1'b0, 1'b0, SW_IDLE, 1'b1)));
        dir_rows.push_back(checked_row(MODE_LINK_ERR, 8'h00,
            plain_result(1'b0, SEM_NONE, 16'd0, 1'b0, 1'b0, SW_IDLE, 1'b0)));
        // queue a switch to bean; a byte while queued is dropped
        dir_rows.push_back(row(MODE_SELECT, 8'h00, 1'b1));
        dir_rows.push_back(checked_row(MODE_RX_BYTE, CHR_L,
            plain_result(1'b0, SEM_NONE, 16'd0, 1'b0, 1'b0, SW_PENDING, 1'b0)));
        // command goes out, wrong-task ack ignored, right ack commits
        dir_rows.push_back(row(MODE_TICK, 8'h00, 1'b0));
        dir_rows.push_back(row(MODE_RX_BYTE, ACK_NUMBER, 1'b0));
        dir_rows.push_back(row(MODE_RX_BYTE, ACK_BEAN, 1'b0));
        // every bean code, then a digit that is wrong for the bean task
        dir_rows.push_back(row(MODE_RX_BYTE, CHR_L, 1'b0));
        dir_rows.push_back(row(MODE_RX_BYTE, CHR_H, 1'b0));
        dir_rows.push_back(row(MODE_RX_BYTE, CMD_BEAN, 1'b0));
        dir_rows.push_back(row(MODE_RX_BYTE, CHR_ONE, 1'b0));
        // back to number: transmitter still busy, so the tick sends nothing
        dir_rows.push_back(row(MODE_SELECT, 8'h00, 1'b0));
        dir_rows.push_back(row(MODE_TICK, 8'h00, 1'b0));
        dir_rows.push_back(row(MODE_TX_DONE, 8'h00, 1'b0));
        dir_rows.push_back(row(MODE_TICK, 8'h00, 1'b0));
        // a byte during the ack wait is dropped, then the wait runs out
        dir_rows.push_back(row(MODE_RX_BYTE, CHR_FIVE - 8'd2, 1'b0));
        dir_rows.push_back(row(MODE_TICK, 8'h00, 1'b0));
        dir_rows.push_back(row(MODE_TICK, 8'h00, 1'b0));
        // unused modes only report the state
        dir_rows.push_back(row(3'd5, 8'hA5, 1'b1));
        dir_rows.push_back(row(3'd7, 8'h5A, 1'b0));

        foreach (dir_rows[i])
            send_event(dir_rows[i].kind, dir_rows[i].ch, dir_rows[i].choice,
                       dir_rows[i].has_result, dir_rows[i].res);
        settle();

        // Random phases: lowest limit, zero (acts as one), short, highest,
        // and a last calm phase.
        limits[0] = 16'd1;
        limits[1] = 16'd0;
        limits[2] = 16'd3;
        limits[3] = 16'hFFFF;
        limits[4] = 16'd2;
        foreach (limits[p])
        begin
            apb_write(limits[p]);
            apb_check_timeout();
            calm = (p == 4);
            // long receiver hold-off while events keep coming
            if (p == 0)
                stall_request = 1'b1;
            target = events_sent + 120;
            while (events_sent < target)
            begin
                if ($urandom_range(0, 1) == 0)
                    switch_sequence();
                else
                    noise_event();
            end
            settle();
        end

        if (mismatches == 0)
            $display("** vision_link_task_switch_handler: PASSED **");
        else
            $display("** vision_link_task_switch_handler: FAILED **");
        $finish;
    end

endmodule
